// ===== design/window3x3_sum_threshold_fill_core_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef WINDOW3X3_SUM_THRESHOLD_FILL_CORE_MACROS_SVH
`define WINDOW3X3_SUM_THRESHOLD_FILL_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define W3S_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define W3S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/w3s_pkg.sv =====
`default_nettype none

package w3s_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int PIXEL_BITS    = 16;
  localparam int PIX_W         = 16;
  localparam int LS_ADDR_BITS  = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 16;
  localparam int SUM_BITS      = 20;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = WIDTH_BITS'(3);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = HEIGHT_BITS'(3);

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST     = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST    = HEIGHT_BITS'(480);
  localparam logic [SUM_BITS-1:0]    THRESHOLD_RST = SUM_BITS'(6);
  localparam logic [PIX_W-1:0]       FILL_RST      = PIX_W'(1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_SUM_THRESHOLD = 2'd2,
    REG_FILL_VALUE    = 2'd3
  } cfg_reg_t;

  // Line store port control, from the core to the storage.
  typedef struct packed {
    logic                    rd_en;
    logic [LS_ADDR_BITS-1:0] rd_addr;
    logic                    wr_en;
    logic [LS_ADDR_BITS-1:0] wr_addr;
  } ls_req_t;

endpackage

`default_nettype wire

// ===== design/w3s_ifs.sv =====
`default_nettype none

// Input pixel channel.
interface w3s_pix_if;
  logic                    valid;
  logic                    ready;
  logic [w3s_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// Result channel.
interface w3s_res_if;
  logic                    valid;
  logic                    ready;
  logic [w3s_pkg::PIX_W-1:0] pixel_out;
  logic                    frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// Register write channel.
interface w3s_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [w3s_pkg::CFG_IDX_BITS-1:0]  index;
  logic [w3s_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/w3s_line_stores.sv =====
`default_nettype none

// The two row buffers. Both are read at one address and written at another
// in the same cycle; read data is registered.
module w3s_line_stores (
  input  wire logic                        clk,
  input  wire w3s_pkg::ls_req_t            req,
  input  wire logic [w3s_pkg::PIX_W-1:0]   wr_older,
  input  wire logic [w3s_pkg::PIX_W-1:0]   wr_newer,
  output logic      [w3s_pkg::PIX_W-1:0]   rd_older,
  output logic      [w3s_pkg::PIX_W-1:0]   rd_newer
);

  logic [w3s_pkg::PIX_W-1:0] mem_older [w3s_pkg::MAX_WIDTH];
  logic [w3s_pkg::PIX_W-1:0] mem_newer [w3s_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_older[req.wr_addr] <= wr_older;
      mem_newer[req.wr_addr] <= wr_newer;
    end
    if (req.rd_en) begin
      rd_older <= mem_older[req.rd_addr];
      rd_newer <= mem_newer[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/window3x3_sum_threshold_fill_core.sv =====
// Channel  Role    Handshake      Payload
// pix      sink    valid/ready    pixel_in[15:0]
// res      source  valid/ready    pixel_out[15:0], frame_last
// cfg      sink    valid/ready    index[1:0], data[19:0]
//
// Throughput is one pixel per clock unless res stalls; the limit is the single read port and
// single write port of each line store, which are used once per pixel.
// An accepted pixel goes through the window stage and then the result register to res.
// Reset (rst, synchronous) clears the counters, the window and the valid
// flags and loads the register defaults; the line stores are not cleared.
// A stall on res holds the result register, then the window stage, and
// drops pix.ready; a pixel that makes no result never waits for res.
`default_nettype none

module window3x3_sum_threshold_fill_core (
  input wire logic   clk,
  input wire logic   rst,
  w3s_pix_if.sink    pix,
  w3s_res_if.source  res,
  w3s_cfg_if.sink    cfg
);

  localparam int PW = w3s_pkg::PIX_W;
  localparam int AW = w3s_pkg::LS_ADDR_BITS;
  localparam int WB = w3s_pkg::WIDTH_BITS;
  localparam int HB = w3s_pkg::HEIGHT_BITS;
  localparam int SB = w3s_pkg::SUM_BITS;

  // Configuration registers. Writes must come only while the block is idle; the block
  // itself does not enforce this. The channel is always ready.
  logic [WB-1:0] image_width;
  logic [HB-1:0] image_height;
  logic [SB-1:0] sum_threshold;
  logic [PW-1:0] fill_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= w3s_pkg::WIDTH_RST;
      image_height  <= w3s_pkg::HEIGHT_RST;
      sum_threshold <= w3s_pkg::THRESHOLD_RST;
      fill_value    <= w3s_pkg::FILL_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (w3s_pkg::cfg_reg_t'(cfg.index))
        w3s_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg.data[WB-1:0];
        w3s_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg.data[HB-1:0];
        w3s_pkg::REG_SUM_THRESHOLD: sum_threshold <= cfg.data[SB-1:0];
        w3s_pkg::REG_FILL_VALUE:    fill_value    <= cfg.data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: width held to 3..MAX_WIDTH, height to at least 3.
  logic [WB-1:0] width_eff;
  logic [HB-1:0] height_eff;
  logic [WB-1:0] last_col;
  logic [HB-1:0] last_row;

  always_comb begin
    if (image_width < w3s_pkg::WIDTH_MIN) begin
      width_eff = w3s_pkg::WIDTH_MIN;
    end else if (image_width > w3s_pkg::WIDTH_MAX) begin
      width_eff = w3s_pkg::WIDTH_MAX;
    end else begin
      width_eff = image_width;
    end
    if (image_height < w3s_pkg::HEIGHT_MIN) begin
      height_eff = w3s_pkg::HEIGHT_MIN;
    end else begin
      height_eff = image_height;
    end
    last_col = width_eff - WB'(1);
    last_row = height_eff - HB'(1);
  end

  // Position of the next pixel. The counters move when a pixel is accepted,
  // since they depend on nothing but the registers.
  logic [AW-1:0] column_count;
  logic [HB-1:0] row_count;
  logic          at_row_end;
  logic          at_frame_rows_end;
  logic          in_fire;

  assign at_row_end        = {{(WB-AW){1'b0}}, column_count} >= last_col;
  assign at_frame_rows_end = row_count >= last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (at_row_end) begin
        column_count <= '0;
        row_count    <= at_frame_rows_end ? '0 : row_count + HB'(1);
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  // Window stage: holds the accepted pixel while the line store read for the
  // same column lands in the store's output register.
  logic          win_valid;
  logic [PW-1:0] win_pix;
  logic [AW-1:0] win_idx;
  logic          win_emit;
  logic          win_last;
  logic          win_adv;
  logic          out_valid;
  logic [PW-1:0] out_pixel;
  logic          out_last;

  // The window stage moves on unless it holds a result and the result
  // register is full and not being taken.
  assign win_adv   = win_valid && (!win_emit || !out_valid || res.ready);
  assign pix.ready = !win_valid || win_adv;
  assign in_fire   = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (pix.ready) begin
      win_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_pix  <= pix.pixel_in & w3s_pkg::PIX_MASK;
      win_idx  <= column_count;
      win_emit <= (row_count >= HB'(2)) && (column_count >= AW'(2));
      win_last <= at_frame_rows_end && at_row_end;
    end
  end

  // Line stores: read the column of the arriving pixel, write the column of
  // the pixel leaving the window stage. Consecutive pixels never share a
  // column, so the two never collide.
  w3s_pkg::ls_req_t ls_req;
  logic [PW-1:0]    top;
  logic [PW-1:0]    mid;
  logic [PW-1:0]    bot;

  assign ls_req.rd_en   = in_fire;
  assign ls_req.rd_addr = column_count;
  assign ls_req.wr_en   = win_adv;
  assign ls_req.wr_addr = win_idx;
  assign bot            = win_pix;

  w3s_line_stores u_line_stores (
    .clk      (clk),
    .req      (ls_req),
    .wr_older (mid),
    .wr_newer (bot),
    .rd_older (top),
    .rd_newer (mid)
  );

  // Two earlier columns of the window: entries 0..2 are the oldest column
  // (top, middle, bottom) and 3..5 the next one.
  logic [PW-1:0] window_columns [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        window_columns[k] <= '0;
      end
    end else if (win_adv) begin
      window_columns[0] <= window_columns[3];
      window_columns[1] <= window_columns[4];
      window_columns[2] <= window_columns[5];
      window_columns[3] <= top;
      window_columns[4] <= mid;
      window_columns[5] <= bot;
    end
  end

  // Nine-pixel sum and threshold test. The sum of nine 16-bit values fits in
  // 20 bits.
  logic [SB-1:0] sum_a;
  logic [SB-1:0] sum_b;
  logic [SB-1:0] sum_c;
  logic [SB-1:0] win_sum;
  logic [PW-1:0] result_pix;

  always_comb begin
    sum_a   = SB'(window_columns[0]) + SB'(window_columns[1]) + SB'(window_columns[2]);
    sum_b   = SB'(window_columns[3]) + SB'(window_columns[4]) + SB'(window_columns[5]);
    sum_c   = SB'(top) + SB'(mid) + SB'(bot);
    win_sum = sum_a + sum_b + sum_c;
    if (win_sum >= sum_threshold) begin
      result_pix = fill_value & w3s_pkg::PIX_MASK;
    end else begin
      result_pix = window_columns[4];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (win_adv && win_emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_adv && win_emit) begin
      out_pixel <= result_pix;
      out_last  <= win_last;
    end
  end

  assign res.valid      = out_valid;
  assign res.pixel_out  = out_pixel;
  assign res.frame_last = out_last;

endmodule

`default_nettype wire

// ===== design/w3s_checker.sv =====
`default_nettype none
`include "window3x3_sum_threshold_fill_core_macros.svh"

module w3s_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [w3s_pkg::PIX_W-1:0] pixel_out,
  input wire logic                      frame_last,
  input wire logic                      cfg_ready
);

  // A stalled result holds its value.
  `W3S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_last), "result changed while stalled")

  // With the result register free or draining, a pixel is always taken.
  `W3S_ASSERT_NOW(a_in_ready, !out_valid || out_ready, in_ready, "input blocked without output stall")

  // No result directly after reset.
  `W3S_ASSERT_NOW(a_rst_empty, $past(rst), !out_valid, "result present right after reset")

  // Register writes are never refused.
  `W3S_ASSERT_NOW(a_cfg_ready, in_valid || !in_valid, cfg_ready, "register channel not ready")

endmodule

bind window3x3_sum_threshold_fill_core w3s_checker u_w3s_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix.valid),
  .in_ready   (pix.ready),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .pixel_out  (res.pixel_out),
  .frame_last (res.frame_last),
  .cfg_ready  (cfg.ready)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the 3x3 window sum / threshold fill core.
// Pixels stream in raster order on the pix channel. Every accepted item runs
// through a local copy of the line stores, the window columns and the
// row/column counters, and that copy predicts the result (if any) the item
// produces. The predictions wait in a queue, and each item on the res channel
// is checked against the oldest of them. Registers are only written while
// the core is idle, normally at frame boundaries. The one exception is the
// tall-frame phase: there the height, threshold and fill change between two
// rows. The width never changes mid-frame, so an unwritten line store entry
// is never read into a result.
module testbench;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  // Time the core gets to go quiet after the last queued result.
  localparam int DRAIN_CYCLES     = 4;
  localparam int RANDOM_ITEMS     = 330;
  localparam int MAX_REPORTS      = 10;

  // Flavors of pixel content. Each one keeps the window sums close to the
  // threshold picked for it, so that both outcomes show up.
  typedef enum int {
    MIX_FULL,
    MIX_LOW,
    MIX_NEAR_MAX,
    MIX_SPARSE
  } pixel_mix_t;

  // Receiver pacing patterns.
  typedef enum int {
    PACE_OPEN,
    PACE_HALF,
    PACE_SPARSE,
    PACE_MOSTLY
  } sink_pace_t;

  typedef struct packed {
    logic [w3s_pkg::PIX_W-1:0] pix;
    logic                      last;
  } filter_out_t;

  // One row of the directed stimulus. Where typed is set, the row carries the
  // result it must produce, worked out by hand.
  typedef struct packed {
    logic [w3s_pkg::PIX_W-1:0] value;
    logic                      typed;
    logic [w3s_pkg::PIX_W-1:0] typed_pix;
    logic                      typed_last;
  } dir_row_t;

  // Three 3x3 frames under the reset threshold (6) and fill (1):
  // a saturated window, a sum of exactly six with a zero center, and a sum
  // of five whose center of 2 must pass through unchanged.
  localparam dir_row_t DIRECTED_ROWS [27] = '{
    '{16'hFFFF, 1'b0, 16'd0, 1'b0}, '{16'hFFFF, 1'b0, 16'd0, 1'b0},
    '{16'hFFFF, 1'b0, 16'd0, 1'b0}, '{16'hFFFF, 1'b0, 16'd0, 1'b0},
    '{16'hFFFF, 1'b0, 16'd0, 1'b0}, '{16'hFFFF, 1'b0, 16'd0, 1'b0},
    '{16'hFFFF, 1'b0, 16'd0, 1'b0}, '{16'hFFFF, 1'b0, 16'd0, 1'b0},
    '{16'hFFFF, 1'b1, 16'd1, 1'b1},
    '{16'd1, 1'b0, 16'd0, 1'b0}, '{16'd1, 1'b0, 16'd0, 1'b0},
    '{16'd1, 1'b0, 16'd0, 1'b0}, '{16'd1, 1'b0, 16'd0, 1'b0},
    '{16'd0, 1'b0, 16'd0, 1'b0}, '{16'd1, 1'b0, 16'd0, 1'b0},
    '{16'd0, 1'b0, 16'd0, 1'b0}, '{16'd1, 1'b0, 16'd0, 1'b0},
    '{16'd0, 1'b1, 16'd1, 1'b1},
    '{16'd1, 1'b0, 16'd0, 1'b0}, '{16'd0, 1'b0, 16'd0, 1'b0},
    '{16'd1, 1'b0, 16'd0, 1'b0}, '{16'd0, 1'b0, 16'd0, 1'b0},
    '{16'd2, 1'b0, 16'd0, 1'b0}, '{16'd0, 1'b0, 16'd0, 1'b0},
    '{16'd1, 1'b0, 16'd0, 1'b0}, '{16'd0, 1'b0, 16'd0, 1'b0},
    '{16'd0, 1'b1, 16'd2, 1'b1}
  };

  logic clk;
  logic rst;

  w3s_pix_if pix_ch ();
  w3s_res_if res_ch ();
  w3s_cfg_if cfg_ch ();

  window3x3_sum_threshold_fill_core dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Local copy of the register file, loaded with the reset defaults.
  logic [w3s_pkg::WIDTH_BITS-1:0]  sh_width     = w3s_pkg::WIDTH_RST;
  logic [w3s_pkg::HEIGHT_BITS-1:0] sh_height    = w3s_pkg::HEIGHT_RST;
  logic [w3s_pkg::SUM_BITS-1:0]    sh_threshold = w3s_pkg::THRESHOLD_RST;
  logic [w3s_pkg::PIX_W-1:0]       sh_fill      = w3s_pkg::FILL_RST;

  // Local copy of the filter state. The line stores start at zero here; with
  // the width held fixed inside a frame their starting value never reaches a
  // result.
  logic [w3s_pkg::PIX_W-1:0] older_row [w3s_pkg::MAX_WIDTH];
  logic [w3s_pkg::PIX_W-1:0] newer_row [w3s_pkg::MAX_WIDTH];
  logic [w3s_pkg::PIX_W-1:0] win_cols [6];
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;

  filter_out_t awaited_out[$];
  int          failures      = 0;
  int          burst_left    = 0;
  int          hold_requests = 0;
  int          stalled_cycles = 0;

  initial begin
    foreach (older_row[i]) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("mismatch %0d at %0t: %s", failures, $time, msg);
  endtask

  // Register values as the core uses them: width held to 3..MAX_WIDTH,
  // height to at least 3.
  function automatic int unsigned used_width();
    int unsigned w;
    w = sh_width;
    if (w < w3s_pkg::WIDTH_MIN) w = w3s_pkg::WIDTH_MIN;
    if (w > w3s_pkg::MAX_WIDTH) w = w3s_pkg::MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned used_height();
    int unsigned h;
    h = sh_height;
    if (h < w3s_pkg::HEIGHT_MIN) h = w3s_pkg::HEIGHT_MIN;
    return h;
  endfunction

  // Advances the local filter state by one pixel. It returns 1 when the pixel
  // completes a window, and then the result holds the predicted output.
  function automatic bit predict_window(input logic [w3s_pkg::PIX_W-1:0] bottom,
                                        output filter_out_t result);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    int unsigned total;
    int          k;
    logic [w3s_pkg::PIX_W-1:0] upper;
    logic [w3s_pkg::PIX_W-1:0] middle;
    bit          has;
    w = used_width();
    h = used_height();
    idx = col_pos % w3s_pkg::MAX_WIDTH;
    upper = older_row[idx];
    middle = newer_row[idx];
    has = (row_pos >= 2) && (col_pos >= 2);
    result = '0;
    if (has) begin
      total = 0;
      total = total + upper + middle + (bottom & w3s_pkg::PIX_MASK);
      for (k = 0; k < 6; k++) total = total + win_cols[k];
      result.pix = (total >= sh_threshold) ? (sh_fill & w3s_pkg::PIX_MASK) : win_cols[4];
      result.last = (row_pos >= h - 1) && (col_pos >= w - 1);
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = upper;
    win_cols[4] = middle;
    win_cols[5] = bottom & w3s_pkg::PIX_MASK;
    older_row[idx] = middle;
    newer_row[idx] = bottom & w3s_pkg::PIX_MASK;
    // A counter already past a shrunken limit wraps at the end of this pixel
    // or row, the same as one that is exactly at it.
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return has;
  endfunction

  function automatic logic [w3s_pkg::PIX_W-1:0] pick_pixel(input pixel_mix_t mix);
    case (mix)
      MIX_LOW:      return w3s_pkg::PIX_W'($urandom_range(0, 3));
      MIX_NEAR_MAX: return ($urandom_range(0, 5) == 0)
                           ? w3s_pkg::PIX_W'(16'hFFFF - $urandom_range(1, 8)) : 16'hFFFF;
      MIX_SPARSE:   return ($urandom_range(0, 5) == 0)
                           ? w3s_pkg::PIX_W'($urandom_range(0, 65535)) : '0;
      default:      return w3s_pkg::PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [w3s_pkg::SUM_BITS-1:0] pick_threshold(input pixel_mix_t mix);
    case (mix)
      MIX_LOW:      return w3s_pkg::SUM_BITS'($urandom_range(5, 22));
      MIX_NEAR_MAX: return w3s_pkg::SUM_BITS'($urandom_range(589790, 589815));
      MIX_SPARSE:   return w3s_pkg::SUM_BITS'($urandom_range(0, 60000));
      default:      return w3s_pkg::SUM_BITS'($urandom_range(200000, 400000));
    endcase
  endfunction

  // Writes one register and mirrors it into the local copy once accepted.
  task automatic write_reg(input w3s_pkg::cfg_reg_t which,
                           input logic [w3s_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (which)
      w3s_pkg::REG_IMAGE_WIDTH:   sh_width     = value[w3s_pkg::WIDTH_BITS-1:0];
      w3s_pkg::REG_IMAGE_HEIGHT:  sh_height    = value[w3s_pkg::HEIGHT_BITS-1:0];
      w3s_pkg::REG_SUM_THRESHOLD: sh_threshold = value[w3s_pkg::SUM_BITS-1:0];
      w3s_pkg::REG_FILL_VALUE:    sh_fill      = value[w3s_pkg::PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one pixel item. The sender runs in bursts; a new burst may start
  // after a gap with valid low. Within a burst valid stays high from one item
  // to the next. When the item is accepted, the prediction is queued; rows
  // with a hand-worked result queue that instead.
  task automatic offer_pixel(input logic [w3s_pkg::PIX_W-1:0] value, input bit typed,
                             input logic [w3s_pkg::PIX_W-1:0] typed_pix,
                             input bit typed_last);
    int          gap;
    filter_out_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_in <= value;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    burst_left--;
    if (predict_window(value, predicted)) begin
      if (typed) begin
        predicted.pix  = typed_pix;
        predicted.last = typed_last;
      end
      awaited_out.push_back(predicted);
    end
  endtask

  task automatic send_pixels(input int count, input pixel_mix_t mix);
    int n;
    for (n = 0; n < count; n++) offer_pixel(pick_pixel(mix), 1'b0, '0, 1'b0);
  endtask

  // Drops valid, waits for every queued result, then lets the last items
  // that make no result leave the pipeline before any register write.
  task automatic settle_block();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result checker: each accepted item on res is matched field by field
  // against the oldest prediction.
  always @(posedge clk) begin : check_results
    filter_out_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (awaited_out.size() == 0) begin
        note_failure($sformatf("unexpected result pixel_out=%0d frame_last=%0b",
                               res_ch.pixel_out, res_ch.frame_last));
      end else begin
        want = awaited_out.pop_front();
        if (res_ch.pixel_out !== want.pix)
          note_failure($sformatf("pixel_out expected %0d got %0d", want.pix, res_ch.pixel_out));
        if (res_ch.frame_last !== want.last)
          note_failure($sformatf("frame_last expected %0b got %0b", want.last,
                                 res_ch.frame_last));
      end
    end
  end

  // Receiver pacing. It switches between patterns of random length. A hold
  // request from the stimulus makes it refuse results for a long stretch
  // while the sender keeps offering, so the core fills and stalls its input.
  initial begin : sink_pacing
    sink_pace_t pace;
    int         pace_left;
    int         hold_left;
    int         holds_served;
    res_ch.ready = 1'b0;
    pace = PACE_OPEN;
    pace_left = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests > holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace = sink_pace_t'($urandom_range(0, 3));
          pace_left = $urandom_range(4, 40);
        end
        pace_left--;
        case (pace)
          PACE_OPEN:   res_ch.ready <= 1'b1;
          PACE_HALF:   res_ch.ready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     res_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no item has moved on any channel for too
  // long. The longest correct stretch is the receiver's long hold.
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles = stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_mix_t mix;
    int         random_items;
    int         pixels;
    random_items = 0;
    rst = 1'b1;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = w3s_pkg::REG_IMAGE_WIDTH;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames at 3x3, with the threshold and fill left at reset.
    write_reg(w3s_pkg::REG_IMAGE_WIDTH, w3s_pkg::CFG_DATA_BITS'(3));
    write_reg(w3s_pkg::REG_IMAGE_HEIGHT, w3s_pkg::CFG_DATA_BITS'(3));
    foreach (DIRECTED_ROWS[i]) begin
      offer_pixel(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].typed_pix, DIRECTED_ROWS[i].typed_last);
    end
    settle_block();

    // Largest possible sum against the largest meaningful threshold. A width
    // of 1 and a height of 2 are both held up to 3.
    write_reg(w3s_pkg::REG_SUM_THRESHOLD, w3s_pkg::CFG_DATA_BITS'(589815));
    write_reg(w3s_pkg::REG_FILL_VALUE, w3s_pkg::CFG_DATA_BITS'(16'hFFFF));
    write_reg(w3s_pkg::REG_IMAGE_WIDTH, w3s_pkg::CFG_DATA_BITS'(1));
    write_reg(w3s_pkg::REG_IMAGE_HEIGHT, w3s_pkg::CFG_DATA_BITS'(2));
    send_pixels(36, MIX_NEAR_MAX);
    settle_block();

    // A threshold of zero fills every window; a fill of zero.
    write_reg(w3s_pkg::REG_SUM_THRESHOLD, '0);
    write_reg(w3s_pkg::REG_FILL_VALUE, '0);
    write_reg(w3s_pkg::REG_IMAGE_WIDTH, w3s_pkg::CFG_DATA_BITS'(5));
    write_reg(w3s_pkg::REG_IMAGE_HEIGHT, w3s_pkg::CFG_DATA_BITS'(4));
    send_pixels(20, MIX_FULL);
    settle_block();

    // A threshold above any reachable sum: every center passes through.
    write_reg(w3s_pkg::REG_SUM_THRESHOLD, {w3s_pkg::CFG_DATA_BITS{1'b1}});
    write_reg(w3s_pkg::REG_FILL_VALUE, w3s_pkg::CFG_DATA_BITS'(16'h5AA5));
    send_pixels(20, MIX_FULL);
    settle_block();

    // Tallest frame: twelve rows at the maximum height, then the height
    // shrinks below the current row, so the next row closes the frame. The
    // threshold and fill change here too and count from the next pixel on.
    write_reg(w3s_pkg::REG_IMAGE_WIDTH, w3s_pkg::CFG_DATA_BITS'(3));
    write_reg(w3s_pkg::REG_IMAGE_HEIGHT, w3s_pkg::CFG_DATA_BITS'(16'hFFFF));
    write_reg(w3s_pkg::REG_SUM_THRESHOLD, pick_threshold(MIX_FULL));
    send_pixels(36, MIX_FULL);
    settle_block();
    write_reg(w3s_pkg::REG_SUM_THRESHOLD, pick_threshold(MIX_FULL));
    write_reg(w3s_pkg::REG_FILL_VALUE, w3s_pkg::CFG_DATA_BITS'($urandom_range(0, 65535)));
    write_reg(w3s_pkg::REG_IMAGE_HEIGHT, w3s_pkg::CFG_DATA_BITS'(5));
    send_pixels(3, MIX_FULL);
    settle_block();

    // Back-pressure: the receiver holds off while a whole frame is offered.
    write_reg(w3s_pkg::REG_IMAGE_WIDTH, w3s_pkg::CFG_DATA_BITS'(10));
    write_reg(w3s_pkg::REG_IMAGE_HEIGHT, w3s_pkg::CFG_DATA_BITS'(8));
    write_reg(w3s_pkg::REG_SUM_THRESHOLD, pick_threshold(MIX_FULL));
    hold_requests++;
    send_pixels(80, MIX_FULL);
    settle_block();

    // Random frames, mostly small, with a fresh setting for each phase.
    while (random_items < RANDOM_ITEMS) begin
      mix = pixel_mix_t'($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) begin
        write_reg(w3s_pkg::REG_IMAGE_WIDTH, ($urandom_range(0, 5) == 0)
                  ? w3s_pkg::CFG_DATA_BITS'($urandom_range(0, 2))
                  : w3s_pkg::CFG_DATA_BITS'($urandom_range(3, 14)));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(w3s_pkg::REG_IMAGE_HEIGHT, ($urandom_range(0, 5) == 0)
                  ? w3s_pkg::CFG_DATA_BITS'($urandom_range(0, 2))
                  : w3s_pkg::CFG_DATA_BITS'($urandom_range(3, 9)));
      end
      write_reg(w3s_pkg::REG_SUM_THRESHOLD, pick_threshold(mix));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(w3s_pkg::REG_FILL_VALUE, w3s_pkg::CFG_DATA_BITS'($urandom_range(0, 65535)));
      end
      pixels = used_width() * used_height() * $urandom_range(1, 2);
      send_pixels(pixels, mix);
      random_items += pixels;
      settle_block();
    end

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
